@@ design/chtab_pkg.sv @@
// shared types, codes and constants of the callsign hash table
`timescale 1ns / 1ps
package chtab_pkg;

	// default number of table entries
	localparam int TABLE_ENTRIES_DEF = 256;

	// field widths
	localparam int HASH_W   = 22;
	localparam int CALL_HI_W = 64;
	localparam int CALL_LO_W = 24;

	// save start index: ((hash >> 12) & 0x3FF) * 23 before the modulo
	localparam int START_SHIFT = 12;
	localparam int START_W     = 10;
	localparam int START_MUL   = 23;
	localparam int PROD_W      = 15;

	// lookup kind shifts and widths
	localparam int K12_SHIFT = 10;
	localparam int K12_W     = 12;
	localparam int K10_SHIFT = 12;
	localparam int K10_W     = 10;

	// operation codes
	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_SAVE   = 2'd1;
	localparam logic [1:0] FUNC_LOOKUP = 2'd2;

	// lookup hash kinds
	localparam logic [1:0] KIND_22 = 2'd0;
	localparam logic [1:0] KIND_12 = 2'd1;

	// one table entry
	typedef struct packed {
		logic [CALL_HI_W-1:0] call_hi;
		logic [CALL_LO_W-1:0] call_lo;
		logic [HASH_W-1:0]    hash;
	} entry_t;

	// control of each cell of the ring; clr and shift are shared, wr goes to the head cell only
	typedef struct packed {
		logic clr;
		logic shift;
		logic wr;
	} cell_ctrl_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_ALIGN,
		ST_PROBE
	} state_t;

endpackage

@@ design/chtab_cell.sv @@
// one storage cell of the rotating entry ring
`timescale 1ns / 1ps
module chtab_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  chtab_pkg::cell_ctrl_t ctrl,
	input  chtab_pkg::entry_t   wr_data,
	input  chtab_pkg::entry_t   nb_data,
	output chtab_pkg::entry_t   data
);

	chtab_pkg::entry_t data_q;

	// clear, write at the head, or take the neighbor's entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctrl.clr) begin
			data_q <= '0;
		end else if (ctrl.wr) begin
			data_q <= wr_data;
		end else if (ctrl.shift) begin
			data_q <= nb_data;
		end
	end

	assign data = data_q;

endmodule

@@ design/chtab_mod.sv @@
// remainder of the save start product by the table size, by reciprocal multiplication
`timescale 1ns / 1ps
module chtab_mod #(
	parameter int TABLE_ENTRIES = chtab_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  logic [chtab_pkg::PROD_W-1:0]     prod,
	output logic                             done,
	output logic [$clog2(TABLE_ENTRIES)-1:0] rem
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int PW = chtab_pkg::PROD_W;
	// quotient is exact for every product below 2**PW with this shift
	localparam int SH = PW + IW;
	localparam int MW = PW + 2;
	localparam logic [MW-1:0] RECIP =
		MW'(((1 << SH) + TABLE_ENTRIES - 1) / TABLE_ENTRIES);
	localparam logic [PW-1:0] N_P = PW'(TABLE_ENTRIES);

	logic [PW+MW-1:0] mul;
	logic [PW-1:0]    quot;
	logic [2*PW-1:0]  qn;
	logic [PW-1:0]    prod_s1;
	logic [PW-1:0]    quot_s1;
	logic             valid_s1;
	logic [IW-1:0]    rem_s2;
	logic             done_s2;

	// quotient by reciprocal, then product minus quotient times size
	always_comb begin
		mul  = prod * RECIP;
		quot = PW'(mul >> SH);
		qn   = quot_s1 * N_P;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s1  <= '0;
			quot_s1  <= '0;
			valid_s1 <= 1'b0;
			rem_s2   <= '0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= load;
			done_s2  <= valid_s1;
			if (load) begin
				prod_s1 <= prod;
				quot_s1 <= quot;
			end
			if (valid_s1) begin
				rem_s2 <= IW'(prod_s1 - qn[PW-1:0]);
			end
		end
	end

	assign done = done_s2;
	assign rem  = rem_s2;

	// checks
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_s2 |-> (rem_s2 <= IW'(TABLE_ENTRIES - 1)))
		else $error("remainder out of range");

endmodule

@@ design/callsign_hash_table.sv @@
// top level: callsign hash table on a rotating ring of entry cells
`timescale 1ns / 1ps
// The table is a ring of TABLE_ENTRIES cells that rotates by one entry per cycle
// while it is turned or probed; only the head cell is read and written, but a
// clear zeroes every cell. A transaction is taken when start is high and busy is
// low; its result appears for one cycle with done high, in the same cycle that
// busy falls, and cannot be held off. Clear and an unknown func never raise busy
// and give their result in the cycle after acceptance. A lookup turns the ring
// back to entry 0 and then scans it, one entry per cycle. A save first waits for
// the remainder unit that finds its start entry, then turns the ring to that
// entry and probes for a free one.
module callsign_hash_table #(
	parameter int TABLE_ENTRIES = chtab_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        func,
	input  logic [1:0]                        hash_kind,
	input  logic [chtab_pkg::HASH_W-1:0]      hash_value,
	input  logic [chtab_pkg::CALL_HI_W-1:0]   call_hi,
	input  logic [chtab_pkg::CALL_LO_W-1:0]   call_lo,
	output logic                              done,
	output logic                              found,
	output logic [chtab_pkg::CALL_HI_W-1:0]   result_hi,
	output logic [chtab_pkg::CALL_LO_W-1:0]   result_lo
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

	chtab_pkg::state_t state_q, state_d;
	chtab_pkg::entry_t cells [TABLE_ENTRIES];
	chtab_pkg::entry_t wr_entry;
	chtab_pkg::cell_ctrl_t ctrl;

	logic [IW-1:0]                 rot_q, rot_d;
	logic [IW-1:0]                 tgt_q, tgt_d;
	logic [IW-1:0]                 cnt_q, cnt_d;
	logic                          save_q, save_d;
	logic [1:0]                    kind_q;
	logic [chtab_pkg::HASH_W-1:0]  hash_q;
	logic [chtab_pkg::CALL_HI_W-1:0] chi_q;
	logic [chtab_pkg::CALL_LO_W-1:0] clo_q;
	logic [chtab_pkg::CALL_HI_W-1:0] cut_hi;
	logic [chtab_pkg::CALL_LO_W-1:0] cut_lo;
	logic                          accept;
	logic                          mod_load;
	logic                          mod_done;
	logic [IW-1:0]                 mod_rem;
	logic [chtab_pkg::PROD_W-1:0]  prod;
	logic                          head_used;
	logic                          head_match;
	logic                          done_d, found_d, hit_d;
	logic                          done_q, found_q;
	logic [chtab_pkg::CALL_HI_W-1:0] res_hi_q;
	logic [chtab_pkg::CALL_LO_W-1:0] res_lo_q;

	assign accept = start && !busy;
	assign busy   = (state_q != chtab_pkg::ST_IDLE);

	// cut the callsign at its first zero byte
	always_comb begin
		logic ended;
		ended  = 1'b0;
		cut_hi = call_hi;
		cut_lo = call_lo;
		for (int k = 0; k < 8; k++) begin
			if (call_hi[63-8*k -: 8] == 8'd0) ended = 1'b1;
			if (ended) cut_hi[63-8*k -: 8] = 8'd0;
		end
		for (int k = 0; k < 3; k++) begin
			if (call_lo[23-8*k -: 8] == 8'd0) ended = 1'b1;
			if (ended) cut_lo[23-8*k -: 8] = 8'd0;
		end
	end

	// save start product before the modulo
	assign prod = chtab_pkg::PROD_W'(
		hash_value[chtab_pkg::START_SHIFT +: chtab_pkg::START_W] * chtab_pkg::START_MUL);

	chtab_mod #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (mod_load),
		.prod   (prod),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	// ring of cells; cell 0 is the head and takes writes
	assign wr_entry = '{call_hi: chi_q, call_lo: clo_q, hash: hash_q};

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		chtab_pkg::cell_ctrl_t c;
		assign c = '{clr: ctrl.clr, shift: ctrl.shift, wr: (i == 0) ? ctrl.wr : 1'b0};
		chtab_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (c),
			.wr_data (wr_entry),
			.nb_data (cells[(i + 1) % TABLE_ENTRIES]),
			.data    (cells[i])
		);
	end

	// head cell compare
	always_comb begin
		head_used = (cells[0].call_hi[63:56] != 8'd0);
		case (kind_q)
			chtab_pkg::KIND_22: head_match = (cells[0].hash == hash_q);
			chtab_pkg::KIND_12: head_match =
				(cells[0].hash[chtab_pkg::K12_SHIFT +: chtab_pkg::K12_W]
				 == hash_q[chtab_pkg::K12_W-1:0]);
			default: head_match =
				(cells[0].hash[chtab_pkg::K10_SHIFT +: chtab_pkg::K10_W]
				 == hash_q[chtab_pkg::K10_W-1:0]);
		endcase
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chtab_pkg::ST_IDLE;
			rot_q   <= '0;
			tgt_q   <= '0;
			cnt_q   <= '0;
			save_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rot_q   <= rot_d;
			tgt_q   <= tgt_d;
			cnt_q   <= cnt_d;
			save_q  <= save_d;
		end
	end

	// latch the transaction payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= '0;
			hash_q <= '0;
			chi_q  <= '0;
			clo_q  <= '0;
		end else if (accept) begin
			kind_q <= hash_kind;
			hash_q <= hash_value;
			chi_q  <= cut_hi;
			clo_q  <= cut_lo;
		end
	end

	// next state and ring control
	always_comb begin
		state_d    = state_q;
		rot_d      = rot_q;
		tgt_d      = tgt_q;
		cnt_d      = cnt_q;
		save_d     = save_q;
		ctrl       = '0;
		mod_load   = 1'b0;
		done_d     = 1'b0;
		found_d    = 1'b0;
		hit_d      = 1'b0;
		case (state_q)
			chtab_pkg::ST_IDLE: begin
				if (accept) begin
					case (func)
						chtab_pkg::FUNC_CLEAR: begin
							ctrl.clr = 1'b1;
							done_d   = 1'b1;
							found_d  = 1'b1;
						end
						chtab_pkg::FUNC_SAVE: begin
							mod_load = 1'b1;
							save_d   = 1'b1;
							state_d  = chtab_pkg::ST_MOD;
						end
						chtab_pkg::FUNC_LOOKUP: begin
							tgt_d   = '0;
							save_d  = 1'b0;
							state_d = chtab_pkg::ST_ALIGN;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			chtab_pkg::ST_MOD: begin
				if (mod_done) begin
					tgt_d   = mod_rem;
					state_d = chtab_pkg::ST_ALIGN;
				end
			end
			chtab_pkg::ST_ALIGN: begin
				if (rot_q == tgt_q) begin
					cnt_d   = '0;
					state_d = chtab_pkg::ST_PROBE;
				end else begin
					ctrl.shift = 1'b1;
					rot_d      = (rot_q == LAST) ? '0 : rot_q + 1'b1;
				end
			end
			chtab_pkg::ST_PROBE: begin
				if (save_q && !head_used) begin
					ctrl.wr = 1'b1;
					done_d  = 1'b1;
					found_d = 1'b1;
					state_d = chtab_pkg::ST_IDLE;
				end else if (!save_q && head_used && head_match) begin
					done_d  = 1'b1;
					found_d = 1'b1;
					hit_d   = 1'b1;
					state_d = chtab_pkg::ST_IDLE;
				end else if (cnt_q == LAST) begin
					done_d  = 1'b1;
					state_d = chtab_pkg::ST_IDLE;
				end else begin
					ctrl.shift = 1'b1;
					rot_d      = (rot_q == LAST) ? '0 : rot_q + 1'b1;
					cnt_d      = cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = chtab_pkg::ST_IDLE;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			res_hi_q <= '0;
			res_lo_q <= '0;
		end else begin
			done_q   <= done_d;
			found_q  <= found_d;
			res_hi_q <= hit_d ? cells[0].call_hi : '0;
			res_lo_q <= hit_d ? cells[0].call_lo : '0;
		end
	end

	assign done      = done_q;
	assign found     = found_q;
	assign result_hi = res_hi_q;
	assign result_lo = res_lo_q;

	// checks
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy) || $past(accept))
		else $error("result without a transaction");
	a_result_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		(res_hi_q != '0 || res_lo_q != '0) |-> found_q)
		else $error("callsign returned without a hit");
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rot_q <= LAST)
		else $error("ring position out of range");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result while a transaction is still running");

endmodule
